FILE: rtl/core/rpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_pkg
// shared constants and types for the permutation-by-removal block
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int unsigned SET_SIZE = 12;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OUT_W    = 4;
  localparam int unsigned VAL_W    = $clog2(SET_SIZE + 1);
  localparam int unsigned IDX_W    = (SET_SIZE > 2) ? $clog2(SET_SIZE) : 1;
  localparam int unsigned CNT_W    = IDX_W;
  localparam int unsigned STEP_W   = $clog2(WORD_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic refill;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rpr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_cell
// one entry of the remaining-value list, takes its upper neighbor on a shift
// ----------------------------------------------------------------------------
module rpr_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rpr_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [rpr_pkg::VAL_W-1:0] init_val_i,
  input  wire logic [rpr_pkg::VAL_W-1:0] next_i,
  output logic      [rpr_pkg::VAL_W-1:0] val_o
);

  logic [rpr_pkg::VAL_W-1:0] val_q;
  logic [rpr_pkg::VAL_W-1:0] val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.refill) begin
      val_d = init_val_i;
    end else if (ctrl_i.shift) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= init_val_i;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpr_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_mod
// bit-serial restoring remainder of a 32-bit magnitude by the list length
// ----------------------------------------------------------------------------
module rpr_mod (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rpr_pkg::WORD_W-1:0] mag_i,
  input  wire logic [rpr_pkg::VAL_W-1:0]  div_i,
  output rpr_pkg::mod_stat_t              stat_o,
  output logic      [rpr_pkg::VAL_W-1:0]  rem_o
);

  logic [rpr_pkg::WORD_W-1:0] mag_q, mag_d;
  logic [rpr_pkg::VAL_W-1:0]  rem_q, rem_d;
  logic [rpr_pkg::VAL_W-1:0]  div_q, div_d;
  logic [rpr_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [rpr_pkg::VAL_W:0]    trial;

  // remainder stays below the divisor, so one compare and subtract per bit
  assign trial = {rem_q, mag_q[rpr_pkg::WORD_W-1]};

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      mag_d  = mag_i;
      rem_d  = '0;
      div_d  = div_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[rpr_pkg::WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = rpr_pkg::VAL_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = rpr_pkg::VAL_W'(trial);
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rpr_pkg::STEP_W'(rpr_pkg::WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/random_permutation_by_removal.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// random_permutation_by_removal
// draws permutations of 1..N one element per random word, removing each pick
// ----------------------------------------------------------------------------
// an accepted word starts the 32-step bit-serial modulo unit (one magnitude
// bit per cycle); the draw is registered when that unit signals done
// one word at a time: a new word is taken only after the last result is taken
// reset: asynchronous active low; list holds 1..N, draw count zero
module random_permutation_by_removal (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [rpr_pkg::WORD_W-1:0] random_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [rpr_pkg::OUT_W-1:0]  drawn_value_o,
  output logic      [rpr_pkg::OUT_W-1:0]  slot_index_o,
  output logic                            last_of_set_o
);

  rpr_pkg::state_e state_q, state_d;

  logic [rpr_pkg::CNT_W-1:0]  count_q, count_d;
  logic [rpr_pkg::OUT_W-1:0]  value_q, slot_q;
  logic                       last_q;

  logic [rpr_pkg::WORD_W-1:0] word_u;
  logic [rpr_pkg::WORD_W-1:0] mag;
  logic [rpr_pkg::VAL_W-1:0]  left;
  logic [rpr_pkg::VAL_W-1:0]  rem;
  logic [rpr_pkg::IDX_W-1:0]  pick;
  logic                       accept;
  logic                       mod_start;
  logic                       commit;
  logic                       last_draw;
  rpr_pkg::mod_stat_t         mod_stat;

  logic [rpr_pkg::VAL_W-1:0]  vals [rpr_pkg::SET_SIZE];
  rpr_pkg::cell_ctrl_t        cell_ctrl [rpr_pkg::SET_SIZE];

  assign accept = in_valid_i && in_ready_o;
  assign word_u = random_word_i;
  // magnitude, most negative word gives 2^31
  assign mag    = word_u[rpr_pkg::WORD_W-1] ? (rpr_pkg::WORD_W'(0) - word_u) : word_u;
  assign left   = rpr_pkg::VAL_W'(rpr_pkg::SET_SIZE) - rpr_pkg::VAL_W'(count_q);

  rpr_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .mag_i  (mag),
    .div_i  (left),
    .stat_o (mod_stat),
    .rem_o  (rem)
  );

  assign pick      = rpr_pkg::IDX_W'(rem);
  assign last_draw = (count_q == rpr_pkg::CNT_W'(rpr_pkg::SET_SIZE - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rpr_pkg::ST_DIV;
        end
      end
      rpr_pkg::ST_DIV: begin
        if (mod_stat.done) begin
          state_d = rpr_pkg::ST_OUT;
        end
      end
      rpr_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = rpr_pkg::ST_IDLE;
        end
      end
      default: state_d = rpr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mod_start   = 1'b0;
    commit      = 1'b0;
    case (state_q)
      rpr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mod_start  = accept;
      end
      rpr_pkg::ST_DIV: begin
        commit = mod_stat.done;
      end
      rpr_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (commit) begin
      count_d = last_draw ? '0 : count_q + 1'b1;
    end
  end

  for (genvar i = 0; i < rpr_pkg::SET_SIZE; i++) begin : g_cell
    logic [rpr_pkg::VAL_W-1:0] next_val;

    if (i == rpr_pkg::SET_SIZE - 1) begin : g_top
      assign next_val = vals[i];
    end else begin : g_mid
      assign next_val = vals[i+1];
    end

    // entries at and above the pick move down one place
    assign cell_ctrl[i] = '{refill: commit && last_draw,
                            shift:  commit && (rpr_pkg::IDX_W'(i) >= pick)};

    rpr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl[i]),
      .init_val_i(rpr_pkg::VAL_W'(i + 1)),
      .next_i    (next_val),
      .val_o     (vals[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpr_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      value_q <= rpr_pkg::OUT_W'(vals[pick]);
      slot_q  <= rpr_pkg::OUT_W'(count_q);
      last_q  <= last_draw;
    end
  end

  assign drawn_value_o = value_q;
  assign slot_index_o  = slot_q;
  assign last_of_set_o = last_q;

endmodule

`default_nettype wire

FILE: tb/sv/rpr_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_draw_checker
// mirrors the pool of undrawn values from the accepted random words and
// checks every drawn element against the oldest owed draw
// ----------------------------------------------------------------------------
module rpr_draw_checker
  import rpr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [WORD_W-1:0] random_word_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [OUT_W-1:0]         drawn_value_i,
  input  logic [OUT_W-1:0]         slot_index_i,
  input  logic                     last_of_set_i,
  output int unsigned              fail_count_o,
  output int unsigned              owed_count_o
);

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [OUT_W-1:0] slot;
    logic             last;
  } draw_t;

  logic [VAL_W-1:0] pool_values [SET_SIZE];
  int unsigned      pool_drawn;
  draw_t            owed_draws [$];

  task automatic refill_pool();
    for (int unsigned i = 0; i < SET_SIZE; i++) begin
      pool_values[i] = VAL_W'(i + 1);
    end
    pool_drawn = 0;
  endtask

  task automatic draw_from_pool(input logic signed [WORD_W-1:0] word);
    logic [WORD_W-1:0] mag;
    int unsigned       left;
    int unsigned       pick;
    draw_t             d;
    if (pool_drawn >= SET_SIZE) begin
      refill_pool();
    end
    // most negative word negates to itself, read unsigned that is 2^31
    mag  = word[WORD_W-1] ? ~word + 1'b1 : word;
    left = SET_SIZE - pool_drawn;
    pick = mag % left;
    d.value = OUT_W'(pool_values[pick]);
    d.slot  = OUT_W'(pool_drawn);
    d.last  = (pool_drawn + 1 == SET_SIZE);
    // close the gap left by the pick
    for (int unsigned i = pick; i + 1 < left; i++) begin
      pool_values[i] = pool_values[i + 1];
    end
    if (d.last) begin
      refill_pool();
    end else begin
      pool_drawn = pool_drawn + 1;
    end
    owed_draws.push_back(d);
  endtask

  function automatic int unsigned field_errors(string field, int unsigned want,
                                               int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t       want;
    int unsigned errs;
    if (!rst_ni) begin
      refill_pool();
      owed_draws.delete();
      fail_count_o <= 0;
      owed_count_o <= 0;
    end else begin
      errs = 0;
      if (out_valid_i && out_ready_i) begin
        if (owed_draws.size() == 0) begin
          $display("%0t: unexpected word, expected none, got value %0d slot %0d last %0b",
                   $time, drawn_value_i, slot_index_i, last_of_set_i);
          errs = 1;
        end else begin
          want = owed_draws.pop_front();
          errs += field_errors("drawn_value", want.value, drawn_value_i);
          errs += field_errors("slot_index", want.slot, slot_index_i);
          errs += field_errors("last_of_set", want.last, last_of_set_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        draw_from_pool(random_word_i);
      end
      fail_count_o <= fail_count_o + errs;
      owed_count_o <= owed_draws.size();
    end
  end

endmodule

FILE: tb/sv/random_permutation_by_removal_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_by_removal_test
// feeds directed and random words to the permutation block with random
// gaps and output stalls; the checker predicts and compares every draw
// ----------------------------------------------------------------------------
module random_permutation_by_removal_test;
  import rpr_pkg::*;

  localparam int unsigned WORD_COUNT  = 400;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic signed [WORD_W-1:0] random_word = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [OUT_W-1:0]         drawn_value;
  logic [OUT_W-1:0]         slot_index;
  logic                     last_of_set;
  logic                     steady      = 1'b0;
  int unsigned              fail_count;
  int unsigned              owed_count;
  int unsigned              quiet_cycles = 0;

  always #2 clk = ~clk;

  random_permutation_by_removal u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .random_word_i(random_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .drawn_value_o(drawn_value),
    .slot_index_o (slot_index),
    .last_of_set_o(last_of_set)
  );

  rpr_draw_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .random_word_i(random_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .drawn_value_i(drawn_value),
    .slot_index_i (slot_index),
    .last_of_set_i(last_of_set),
    .fail_count_o (fail_count),
    .owed_count_o (owed_count)
  );

  // receiver stalls about a quarter of the time outside the steady window
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("** random_permutation_by_removal: FAILED **");
      $finish;
    end
  end

  task automatic push_word(input logic signed [WORD_W-1:0] word);
    if (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid    <= 1'b1;
    random_word <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [WORD_W-1:0] corner_words [12];
    corner_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                     32'h0000_0001, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFF4, 32'h0000_000C};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one whole set that always takes the last live entry
    for (int k = 0; k < SET_SIZE; k++) begin
      push_word(SET_SIZE - 1 - k);
    end
    foreach (corner_words[i]) begin
      push_word(corner_words[i]);
    end

    for (int n = 0; n < WORD_COUNT; n++) begin
      if (n == 100) steady <= 1'b1;
      if (n == 180) steady <= 1'b0;
      if (n == 250) begin
        // hold off until every owed draw has come out
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
      end
      case ($urandom_range(3))
        0:       push_word($urandom_range(40));
        1:       push_word(-$signed($urandom_range(40)));
        default: push_word($urandom());
      endcase
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("** random_permutation_by_removal: PASSED **");
    end else begin
      $display("** random_permutation_by_removal: FAILED **");
    end
    $finish;
  end

endmodule
